// File: src/ffba_pkg.sv
// Package for the first-fit block allocator.
// Holds sizing constants, operation and status codes, and the shared struct types.
// No dependencies; every other file refers to it by scoped names.
package ffba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_BITS  = 16;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W = ADDR_BITS + 1;

	localparam int OP_W    = 2;
	localparam int REQ_W   = 16;
	localparam int FADDR_W = 16;
	localparam int FSIZE_W = 17;
	localparam int ST_W    = 2;
	localparam int MRG_W   = 6;

	localparam int SZC_W = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
	localparam int SUM_W = SZC_W + 1;
	localparam int CMP_W = (ADDR_BITS > FADDR_W) ? ADDR_BITS : FADDR_W;

	localparam longint unsigned ARENA = 64'd1 << ADDR_BITS;

	localparam logic [MRG_W-1:0] MRG_MAX = '1;

	localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
	localparam logic [OP_W-1:0] OP_COALESCE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [REQ_W-1:0]   request_size;
		logic [FADDR_W-1:0] block_address;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [FADDR_W-1:0] granted_address;
		logic [FSIZE_W-1:0] freed_size;
		logic [MRG_W-1:0]   merge_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_W-1:0]    size;
		logic                 free;
	} entry_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic post;
	} dp_ctl_t;

	typedef struct packed {
		logic hit;
		logic done;
		logic rsp_free;
	} dp_sts_t;

endpackage

// File: src/ffba_dp.sv
// Datapath of the first-fit block allocator: block table memory, scan pointers,
// coalesce merge register, result and output registers. Depends on ffba_pkg.
module ffba_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ffba_pkg::cmd_t    cmd,
	input  ffba_pkg::dp_ctl_t ctl,
	output ffba_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ffba_pkg::rsp_t    rsp
);

	ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
	ffba_pkg::entry_t rdata_s1;
	logic             rvalid_s1;
	logic [ffba_pkg::IDX_W-1:0] chk_s1;

	logic [ffba_pkg::OP_W-1:0]    op_q;
	logic [ffba_pkg::REQ_W-1:0]   req_q;
	logic [ffba_pkg::FADDR_W-1:0] addr_q;

	logic [ffba_pkg::CNT_W-1:0]  count_q;
	logic [ffba_pkg::SIZE_W-1:0] top_q;
	logic [ffba_pkg::CNT_W-1:0]  rd_ptr_q;
	logic [ffba_pkg::CNT_W-1:0]  wr_q;
	ffba_pkg::entry_t            cur_q;
	logic                        cur_valid_q;
	logic [ffba_pkg::MRG_W-1:0]  merges_q;
	ffba_pkg::rsp_t              res_q;
	ffba_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;

	logic is_alloc, is_free, is_coal;
	logic issue, fit, match, hit, done, merge, no_room, rsp_free;
	logic [ffba_pkg::SUM_W-1:0] append_sum;

	logic                       wen;
	logic [ffba_pkg::IDX_W-1:0] waddr;
	ffba_pkg::entry_t           wdata;

	always_comb begin
		is_alloc   = op_q == ffba_pkg::OP_ALLOC;
		is_free    = op_q == ffba_pkg::OP_FREE;
		is_coal    = op_q == ffba_pkg::OP_COALESCE;
		issue      = ctl.scan && (rd_ptr_q < count_q);
		fit        = rdata_s1.free &&
			(ffba_pkg::SZC_W'(rdata_s1.size) >= ffba_pkg::SZC_W'(req_q));
		match      = ffba_pkg::CMP_W'(rdata_s1.base) == ffba_pkg::CMP_W'(addr_q);
		hit        = rvalid_s1 && ((is_alloc && fit) || (is_free && match));
		done       = !rvalid_s1 && (rd_ptr_q >= count_q);
		merge      = cur_valid_q && cur_q.free && rdata_s1.free;
		append_sum = ffba_pkg::SUM_W'(top_q) + ffba_pkg::SUM_W'(req_q);
		no_room    = (count_q >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) ||
			top_q[ffba_pkg::ADDR_BITS] ||
			(append_sum > ffba_pkg::SUM_W'(ffba_pkg::ARENA));
		rsp_free   = !rsp_valid_q || !rsp_stall;
	end

	assign sts.hit      = hit;
	assign sts.done     = done;
	assign sts.rsp_free = rsp_free;

	always_comb begin
		wen   = 1'b0;
		waddr = chk_s1;
		wdata = rdata_s1;
		if (ctl.scan) begin
			if (hit) begin
				wen        = 1'b1;
				waddr      = chk_s1;
				wdata.free = is_free;
			end else if (is_coal && rvalid_s1 && !merge && cur_valid_q) begin
				wen   = 1'b1;
				waddr = wr_q[ffba_pkg::IDX_W-1:0];
				wdata = cur_q;
			end else if (done && is_alloc && !no_room) begin
				wen        = 1'b1;
				waddr      = count_q[ffba_pkg::IDX_W-1:0];
				wdata.base = top_q[ffba_pkg::ADDR_BITS-1:0];
				wdata.size = ffba_pkg::SIZE_W'(req_q);
				wdata.free = 1'b0;
			end else if (done && is_coal && cur_valid_q) begin
				wen   = 1'b1;
				waddr = wr_q[ffba_pkg::IDX_W-1:0];
				wdata = cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[rd_ptr_q[ffba_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			top_q       <= '0;
			rd_ptr_q    <= '0;
			wr_q        <= '0;
			rvalid_s1   <= 1'b0;
			cur_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				rd_ptr_q    <= '0;
				wr_q        <= '0;
				rvalid_s1   <= 1'b0;
				cur_valid_q <= 1'b0;
			end else if (ctl.scan) begin
				rvalid_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
				if (is_coal && rvalid_s1 && !merge) begin
					cur_valid_q <= 1'b1;
					if (cur_valid_q) begin
						wr_q <= wr_q + 1'b1;
					end
				end
				if (done && is_alloc && !no_room) begin
					count_q <= count_q + 1'b1;
					top_q   <= top_q + ffba_pkg::SIZE_W'(req_q);
				end
				if (done && is_coal) begin
					count_q <= cur_valid_q ? wr_q + 1'b1 : wr_q;
				end
			end
			if (ctl.post && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q     <= cmd.operation;
			req_q    <= cmd.request_size;
			addr_q   <= cmd.block_address;
			res_q    <= '0;
			merges_q <= '0;
		end else if (ctl.scan) begin
			chk_s1 <= rd_ptr_q[ffba_pkg::IDX_W-1:0];
			if (is_coal && rvalid_s1) begin
				if (merge) begin
					cur_q.size <= cur_q.size + rdata_s1.size;
					if (merges_q != ffba_pkg::MRG_MAX) begin
						merges_q <= merges_q + 1'b1;
					end
				end else begin
					cur_q <= rdata_s1;
				end
			end
			if (hit) begin
				if (is_alloc) begin
					res_q.granted_address <= ffba_pkg::FADDR_W'(rdata_s1.base);
				end else begin
					res_q.freed_size <= ffba_pkg::FSIZE_W'(rdata_s1.size);
				end
			end else if (done) begin
				if (is_alloc) begin
					if (no_room) begin
						res_q.status <= ffba_pkg::ST_FULL;
					end else begin
						res_q.granted_address <=
							ffba_pkg::FADDR_W'(top_q[ffba_pkg::ADDR_BITS-1:0]);
					end
				end else if (is_free) begin
					res_q.status <= ffba_pkg::ST_NOT_FOUND;
				end else if (is_coal) begin
					res_q.merge_count <= merges_q;
				end
			end
		end
		if (ctl.post && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// File: src/ffba_ctrl.sv
// Controller of the first-fit block allocator: sequences accept, table scan
// and hand-off of the result to the output register. Depends on ffba_pkg.
module ffba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              busy,
	output ffba_pkg::dp_ctl_t ctl,
	input  ffba_pkg::dp_sts_t sts
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DONE
	} state_t;

	state_t state_q;

	always_comb begin
		busy      = state_q != IDLE;
		ctl.start = (state_q == IDLE) && cmd_valid;
		ctl.scan  = state_q == SCAN;
		ctl.post  = state_q == DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd_valid) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (sts.hit || sts.done) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (sts.rsp_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/first_fit_block_allocator.sv
// First-fit block allocator with coalescing, top level.
// Instantiates ffba_ctrl and ffba_dp; depends on ffba_pkg.
//
// Usage: a transaction on the cmd channel carries an operation (allocate, free
// or coalesce) with its request size and block address. Each accepted
// transaction yields exactly one transaction on the rsp channel with a status,
// the granted address, the freed size and the merge count.
// The block table sits in a single memory with one read and one write port,
// and an operation walks it one entry per cycle. A transaction stops at the
// first matching table entry or walks the whole table, and its result then
// moves into the output register. cmd_stall is high from acceptance until
// the result has moved into the output register and drops in the cycle
// after. The next transaction may be taken while an earlier result still
// waits on a stalled rsp channel. A stalled rsp transaction holds its
// payload; a second finished result waits inside the block until the
// output register frees up.
// Reset empties the table and sets the arena top to zero at once; no clearing
// pass runs, and the block accepts transactions in the first cycle after reset.
module first_fit_block_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ffba_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffba_pkg::rsp_t rsp
);

	ffba_pkg::dp_ctl_t ctl;
	ffba_pkg::dp_sts_t sts;
	logic              busy;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.busy      (busy),
		.ctl       (ctl),
		.sts       (sts)
	);

	ffba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign cmd_stall = busy;

endmodule

// File: src/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg.
module ffba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ffba_pkg::rsp_t rsp
);

	// A stalled response transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// An accepted command raises cmd_stall, so commands are not accepted back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted back to back");

	// A failed operation returns no address, size or merge count.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ffba_pkg::ST_OK) |->
		(rsp.granted_address == '0) && (rsp.freed_size == '0) &&
		(rsp.merge_count == '0))
		else $error("failed operation carries data");

	// At most one result field is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.granted_address != '0, rsp.freed_size != '0,
		rsp.merge_count != '0}))
		else $error("more than one result field set");

	// The status is always one of the defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ffba_pkg::ST_OK) ||
		(rsp.status == ffba_pkg::ST_NOT_FOUND) || (rsp.status == ffba_pkg::ST_FULL))
		else $error("bad status code");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
